@@ src/i2cmte_pkg.sv @@
package i2cmte_pkg;

    localparam logic [7:0] HOLD_RESET = 8'd10;
    localparam int BYTE_BITS = 8;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_START = 3'd1,
        PH_WLOAD = 3'd2,
        PH_WBIT  = 3'd3,
        PH_ACK   = 3'd4,
        PH_READ  = 3'd5,
        PH_RACK  = 3'd6,
        PH_STOP  = 3'd7
    } t_phase;

    typedef struct packed {
        logic       go;
        logic [7:0] address;
        logic [7:0] byte_count;
        logic [7:0] write_data;
        logic       sda_in;
    } t_in_word;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       byte_taken;
        logic       read_valid;
        logic [7:0] read_data;
        logic       done_res;
        logic       nack_error;
        logic       busy_res;
    } t_out_word;

endpackage

@@ src/i2cmte_fsm.sv @@
module i2cmte_fsm (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  i2cmte_pkg::t_in_word  i_in,
    input  logic [7:0]            i_hold,
    output i2cmte_pkg::t_out_word o_res
);

    i2cmte_pkg::t_phase r_phase, n_phase;
    logic [1:0] r_sub, n_sub;
    logic [3:0] r_bit, n_bit;
    logic [7:0] r_left, n_left;
    logic [7:0] r_shift, n_shift;
    logic       r_read_mode, n_read_mode;
    logic [7:0] r_hold_cnt, n_hold_cnt;
    logic       r_failed, n_failed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= i2cmte_pkg::PH_IDLE;
            r_sub       <= 2'd0;
            r_bit       <= 4'd0;
            r_left      <= 8'd0;
            r_shift     <= 8'd0;
            r_read_mode <= 1'b0;
            r_hold_cnt  <= 8'd0;
            r_failed    <= 1'b0;
        end else if (i_en) begin
            r_phase     <= n_phase;
            r_sub       <= n_sub;
            r_bit       <= n_bit;
            r_left      <= n_left;
            r_shift     <= n_shift;
            r_read_mode <= n_read_mode;
            r_hold_cnt  <= n_hold_cnt;
            r_failed    <= n_failed;
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_sub       = r_sub;
        n_bit       = r_bit;
        n_left      = r_left;
        n_shift     = r_shift;
        n_read_mode = r_read_mode;
        n_hold_cnt  = r_hold_cnt;
        n_failed    = r_failed;
        o_res       = '0;
        o_res.scl_out  = 1'b1;
        o_res.sda_out  = 1'b1;
        o_res.busy_res = 1'b1;
        case (r_phase)
            i2cmte_pkg::PH_START: begin
                o_res.sda_out = 1'b0;
                if (r_sub == 2'd0) begin
                    n_sub = 2'd1;
                end else if (r_hold_cnt != 8'd0) begin
                    n_hold_cnt = r_hold_cnt - 8'd1;
                end else begin
                    o_res.scl_out = 1'b0;
                    n_phase = i2cmte_pkg::PH_WBIT;
                    n_sub   = 2'd0;
                    n_bit   = 4'd0;
                end
            end
            i2cmte_pkg::PH_WLOAD: begin
                n_shift          = i_in.write_data;
                o_res.byte_taken = 1'b1;
                n_left           = r_left - 8'd1;
                o_res.sda_out    = i_in.write_data[7];
                o_res.scl_out    = 1'b0;
                n_phase = i2cmte_pkg::PH_WBIT;
                n_sub   = 2'd1;
                n_bit   = 4'd0;
            end
            i2cmte_pkg::PH_WBIT: begin
                o_res.sda_out = r_shift[7];
                o_res.scl_out = (r_sub == 2'd1);
                if (r_sub >= 2'd2) begin
                    n_shift = {r_shift[6:0], 1'b0};
                    n_sub   = 2'd0;
                    n_bit   = r_bit + 4'd1;
                    if (n_bit >= 4'(i2cmte_pkg::BYTE_BITS)) begin
                        n_phase = i2cmte_pkg::PH_ACK;
                        n_bit   = 4'd0;
                    end
                end else begin
                    n_sub = r_sub + 2'd1;
                end
            end
            i2cmte_pkg::PH_ACK: begin
                if (r_sub == 2'd0) begin
                    o_res.scl_out = 1'b0;
                    n_sub = 2'd1;
                end else if (r_sub == 2'd1) begin
                    n_failed = i_in.sda_in;
                    n_sub    = 2'd2;
                end else begin
                    o_res.scl_out = 1'b0;
                    n_sub = 2'd0;
                    n_bit = 4'd0;
                    if (r_failed || r_left == 8'd0) begin
                        n_phase = i2cmte_pkg::PH_STOP;
                    end else if (r_read_mode) begin
                        n_phase = i2cmte_pkg::PH_READ;
                    end else begin
                        n_phase = i2cmte_pkg::PH_WLOAD;
                    end
                end
            end
            i2cmte_pkg::PH_READ: begin
                if (r_sub == 2'd0) begin
                    o_res.scl_out = 1'b0;
                    n_left = r_left - 8'd1;
                    n_bit  = 4'd0;
                    n_sub  = 2'd1;
                end else if (r_sub == 2'd1) begin
                    n_shift = {r_shift[6:0], i_in.sda_in};
                    if (r_bit == 4'd7) begin
                        o_res.read_valid = 1'b1;
                        o_res.read_data  = n_shift;
                    end
                    n_sub = 2'd2;
                end else begin
                    o_res.scl_out = 1'b0;
                    n_bit = r_bit + 4'd1;
                    n_sub = 2'd1;
                    if (n_bit >= 4'(i2cmte_pkg::BYTE_BITS)) begin
                        n_phase = i2cmte_pkg::PH_RACK;
                        n_sub   = 2'd0;
                        n_bit   = 4'd0;
                    end
                end
            end
            i2cmte_pkg::PH_RACK: begin
                o_res.sda_out = (r_left == 8'd0);
                o_res.scl_out = (r_sub == 2'd1);
                if (r_sub >= 2'd2) begin
                    n_sub   = 2'd0;
                    n_phase = (r_left == 8'd0) ? i2cmte_pkg::PH_STOP
                                               : i2cmte_pkg::PH_READ;
                end else begin
                    n_sub = r_sub + 2'd1;
                end
            end
            i2cmte_pkg::PH_STOP: begin
                if (r_sub == 2'd0) begin
                    o_res.sda_out = 1'b0;
                    n_sub = 2'd1;
                end else begin
                    o_res.done_res   = 1'b1;
                    o_res.nack_error = r_failed;
                    n_phase = i2cmte_pkg::PH_IDLE;
                    n_sub   = 2'd0;
                end
            end
            default: begin
                n_phase = i2cmte_pkg::PH_IDLE;
                n_sub   = 2'd0;
                if (i_in.go) begin
                    n_shift     = i_in.address;
                    n_read_mode = i_in.address[0];
                    n_left      = i_in.byte_count;
                    n_hold_cnt  = i_hold;
                    n_failed    = 1'b0;
                    n_bit       = 4'd0;
                    n_phase     = i2cmte_pkg::PH_START;
                end else begin
                    o_res.busy_res = 1'b0;
                end
            end
        endcase
    end

    a_done_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && o_res.done_res |=> r_phase == i2cmte_pkg::PH_IDLE)
        else $error("done not followed by idle");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_res.done_res, o_res.byte_taken, o_res.read_valid}))
        else $error("done, byte_taken and read_valid overlap");

    a_taken_write_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.byte_taken |-> !r_read_mode)
        else $error("byte taken in a read transaction");

    a_read_valid_read_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.read_valid |-> r_read_mode)
        else $error("read byte in a write transaction");

    a_nack_with_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.nack_error |-> o_res.done_res && o_res.busy_res)
        else $error("nack without done");

endmodule

@@ src/i2c_master_transaction_engine.sv @@
// I2C master that runs one transaction per go request, one bus line state per
// input word. Each accepted word yields exactly one result word carrying the
// SCL/SDA drive for that tick plus status flags. A word is accepted every clock
// while the result register is empty or being drained, and its result appears
// in that register on the next cycle; the single output register also sets the
// one-word-per-cycle throughput. Write the start hold register only while no
// transaction is in progress.
module i2c_master_transaction_engine (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [7:0]            i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  i2cmte_pkg::t_in_word  i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output i2cmte_pkg::t_out_word o_out_data
);

    logic [7:0]            r_hold;
    logic                  r_out_valid;
    i2cmte_pkg::t_out_word r_out_data;
    i2cmte_pkg::t_out_word n_out_data;
    logic                  w_accept;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold <= i2cmte_pkg::HOLD_RESET;
        end else if (i_cfg_we) begin
            r_hold <= i_cfg_data;
        end
    end

    i2cmte_fsm u_fsm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_accept),
        .i_in    (i_in_data),
        .i_hold  (r_hold),
        .o_res   (n_out_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_out_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_data <= n_out_data;
        end
    end

endmodule

@@ dv/tb_i2c_master_transaction_engine.sv @@
module tb_i2c_master_transaction_engine;

    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int PHASE_TICKS = 250;
    localparam int GAP_PCT [4] = '{0, 57, 0, 33};
    localparam int STALL_PCT [4] = '{0, 0, 57, 33};
    localparam i2cmte_pkg::t_out_word IDLE_LINE =
        '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0};

    typedef enum {ROW_IDLE, ROW_TXN, ROW_HOLD} t_row_kind;

    typedef struct {
        t_row_kind             kind;
        logic [7:0]            value;
        logic [7:0]            cnt;
        int                    nack_at;
        int                    wdata;
        i2cmte_pkg::t_out_word want;
    } t_script_row;

    // value is the address byte for a transaction, the hold ticks for a register write
    t_script_row script [0:16] = '{
        '{ROW_IDLE, 8'h00, 8'h00, -1, -1, IDLE_LINE},
        '{ROW_IDLE, 8'h00, 8'h00, -1, -1, IDLE_LINE},
        '{ROW_TXN,  8'hA4, 8'h02, -1, 255, '0},
        '{ROW_TXN,  8'hA4, 8'h01, -1, 0, '0},
        '{ROW_TXN,  8'h55, 8'h03, -1, -1, '0},
        '{ROW_TXN,  8'h00, 8'h00, -1, -1, '0},
        '{ROW_TXN,  8'hFF, 8'h00, -1, -1, '0},
        '{ROW_TXN,  8'h3C, 8'h03, 0, -1, '0},
        '{ROW_TXN,  8'h5A, 8'hFF, 2, -1, '0},
        '{ROW_TXN,  8'h81, 8'h02, 0, -1, '0},
        '{ROW_HOLD, 8'h00, 8'h00, -1, -1, '0},
        '{ROW_TXN,  8'hC2, 8'h01, -1, -1, '0},
        '{ROW_TXN,  8'h43, 8'h01, -1, -1, '0},
        '{ROW_HOLD, 8'hFF, 8'h00, -1, -1, '0},
        '{ROW_TXN,  8'h7E, 8'h01, 1, -1, '0},
        '{ROW_HOLD, i2cmte_pkg::HOLD_RESET, 8'h00, -1, -1, '0},
        '{ROW_IDLE, 8'h00, 8'h00, -1, -1, IDLE_LINE}
    };

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [7:0]            i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_ready;
    i2cmte_pkg::t_in_word  i_in_data;
    logic                  o_out_valid;
    logic                  i_out_ready;
    i2cmte_pkg::t_out_word o_out_data;

    i2c_master_transaction_engine dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // bus engine mirror
    i2cmte_pkg::t_phase m_phase;
    logic [1:0] m_sub;
    logic [3:0] m_bit;
    logic [7:0] m_left;
    logic [7:0] m_shift;
    logic       m_rd;
    logic [7:0] m_hold_cnt;
    logic [7:0] m_hold_cfg;
    logic       m_failed;

    i2cmte_pkg::t_out_word expected_lines [$];
    int mismatches = 0;
    int lines_seen = 0;
    int gap_pct = 0;
    int stall_pct = 0;
    int backpressure_req = 0;
    int backpressure_seen = 0;
    int backpressure_left = 0;
    int quiet_cycles = 0;

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    task automatic engine_reset();
        m_phase = i2cmte_pkg::PH_IDLE;
        m_sub = '0;
        m_bit = '0;
        m_left = '0;
        m_shift = '0;
        m_rd = 1'b0;
        m_hold_cnt = '0;
        m_hold_cfg = i2cmte_pkg::HOLD_RESET;
        m_failed = 1'b0;
    endtask

    function automatic i2cmte_pkg::t_out_word bus_tick(i2cmte_pkg::t_in_word w);
        i2cmte_pkg::t_out_word o;
        o = '0;
        o.scl_out = 1'b1;
        o.sda_out = 1'b1;
        o.busy_res = 1'b1;
        case (m_phase)
            i2cmte_pkg::PH_START: begin
                o.sda_out = 1'b0;
                if (m_sub == 2'd0) begin
                    m_sub = 2'd1;
                end else if (m_hold_cnt != 8'd0) begin
                    m_hold_cnt = m_hold_cnt - 8'd1;
                end else begin
                    o.scl_out = 1'b0;
                    m_phase = i2cmte_pkg::PH_WBIT;
                    m_sub = 2'd0;
                    m_bit = 4'd0;
                end
            end
            i2cmte_pkg::PH_WLOAD: begin
                m_shift = w.write_data;
                o.byte_taken = 1'b1;
                m_left = m_left - 8'd1;
                o.sda_out = m_shift[7];
                o.scl_out = 1'b0;
                m_phase = i2cmte_pkg::PH_WBIT;
                m_sub = 2'd1;
                m_bit = 4'd0;
            end
            i2cmte_pkg::PH_WBIT: begin
                o.sda_out = m_shift[7];
                o.scl_out = (m_sub == 2'd1);
                if (m_sub >= 2'd2) begin
                    m_shift = {m_shift[6:0], 1'b0};
                    m_bit = m_bit + 4'd1;
                    m_sub = 2'd0;
                    if (m_bit >= 4'd8) begin
                        m_phase = i2cmte_pkg::PH_ACK;
                        m_bit = 4'd0;
                    end
                end else begin
                    m_sub = m_sub + 2'd1;
                end
            end
            i2cmte_pkg::PH_ACK: begin
                if (m_sub == 2'd0) begin
                    o.scl_out = 1'b0;
                    m_sub = 2'd1;
                end else if (m_sub == 2'd1) begin
                    m_failed = w.sda_in;
                    m_sub = 2'd2;
                end else begin
                    o.scl_out = 1'b0;
                    m_sub = 2'd0;
                    m_bit = 4'd0;
                    if (m_failed || m_left == 8'd0) m_phase = i2cmte_pkg::PH_STOP;
                    else if (m_rd) m_phase = i2cmte_pkg::PH_READ;
                    else m_phase = i2cmte_pkg::PH_WLOAD;
                end
            end
            i2cmte_pkg::PH_READ: begin
                if (m_sub == 2'd0) begin
                    o.scl_out = 1'b0;
                    m_left = m_left - 8'd1;
                    m_bit = 4'd0;
                    m_sub = 2'd1;
                end else if (m_sub == 2'd1) begin
                    m_shift = {m_shift[6:0], w.sda_in};
                    if (m_bit == 4'd7) begin
                        o.read_valid = 1'b1;
                        o.read_data = m_shift;
                    end
                    m_sub = 2'd2;
                end else begin
                    o.scl_out = 1'b0;
                    m_bit = m_bit + 4'd1;
                    m_sub = 2'd1;
                    if (m_bit >= 4'd8) begin
                        m_phase = i2cmte_pkg::PH_RACK;
                        m_sub = 2'd0;
                        m_bit = 4'd0;
                    end
                end
            end
            i2cmte_pkg::PH_RACK: begin
                o.sda_out = (m_left == 8'd0);
                o.scl_out = (m_sub == 2'd1);
                if (m_sub >= 2'd2) begin
                    m_sub = 2'd0;
                    m_phase = (m_left == 8'd0) ? i2cmte_pkg::PH_STOP
                                               : i2cmte_pkg::PH_READ;
                end else begin
                    m_sub = m_sub + 2'd1;
                end
            end
            i2cmte_pkg::PH_STOP: begin
                if (m_sub == 2'd0) begin
                    o.sda_out = 1'b0;
                    m_sub = 2'd1;
                end else begin
                    o.done_res = 1'b1;
                    o.nack_error = m_failed;
                    m_phase = i2cmte_pkg::PH_IDLE;
                    m_sub = 2'd0;
                end
            end
            default: begin
                m_phase = i2cmte_pkg::PH_IDLE;
                m_sub = 2'd0;
                if (w.go) begin
                    m_shift = w.address;
                    m_rd = w.address[0];
                    m_left = w.byte_count;
                    m_hold_cnt = m_hold_cfg;
                    m_failed = 1'b0;
                    m_bit = 4'd0;
                    m_phase = i2cmte_pkg::PH_START;
                end else begin
                    o.busy_res = 1'b0;
                end
            end
        endcase
        return o;
    endfunction

    // called right after a rising edge, returns at the edge that takes the word
    task automatic send_word(input i2cmte_pkg::t_in_word w, input bit typed = 1'b0,
                             input i2cmte_pkg::t_out_word want = '0);
        i2cmte_pkg::t_out_word line;
        while ($urandom_range(99) < gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= w;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        line = bus_tick(w);
        expected_lines.push_back(typed ? want : line);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (expected_lines.size() != 0);
    endtask

    task automatic set_hold(input logic [7:0] ticks);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_data <= ticks;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        m_hold_cfg = ticks;
    endtask

    // nack_at picks which acknowledge the slave refuses, 0 being the address
    task automatic run_txn(input logic [7:0] addr, input logic [7:0] cnt, input int nack_at,
                           input int wdata, output int ticks);
        i2cmte_pkg::t_in_word w;
        int acks;
        acks = 0;
        w.go = 1'b1;
        w.address = addr;
        w.byte_count = cnt;
        w.write_data = (wdata < 0) ? 8'($urandom_range(255)) : 8'(wdata);
        w.sda_in = 1'($urandom_range(1));
        send_word(w);
        ticks = 1;
        while (m_phase != i2cmte_pkg::PH_IDLE) begin
            w.go = ($urandom_range(3) == 0);
            w.address = 8'($urandom_range(255));
            w.byte_count = 8'($urandom_range(255));
            w.write_data = (wdata < 0) ? 8'($urandom_range(255)) : 8'(wdata);
            w.sda_in = 1'($urandom_range(1));
            if (m_phase == i2cmte_pkg::PH_ACK && m_sub == 2'd1) begin
                w.sda_in = (acks == nack_at);
                acks++;
            end
            send_word(w);
            ticks++;
        end
    endtask

    task automatic report_mismatch(input string field, input logic [7:0] got,
                                   input logic [7:0] want);
        mismatches++;
        $display("mismatch on word %0d: %s got %0h expected %0h",
                 lines_seen, field, got, want);
    endtask

    always @(posedge i_clk) begin
        i2cmte_pkg::t_out_word want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            if (expected_lines.size() == 0) begin
                report_mismatch("unexpected word", o_out_data.read_data, 8'h00);
            end else begin
                want = expected_lines.pop_front();
                if (o_out_data.scl_out !== want.scl_out)
                    report_mismatch("scl_out", 8'(o_out_data.scl_out),
                                    8'(want.scl_out));
                if (o_out_data.sda_out !== want.sda_out)
                    report_mismatch("sda_out", 8'(o_out_data.sda_out),
                                    8'(want.sda_out));
                if (o_out_data.byte_taken !== want.byte_taken)
                    report_mismatch("byte_taken", 8'(o_out_data.byte_taken),
                                    8'(want.byte_taken));
                if (o_out_data.read_valid !== want.read_valid)
                    report_mismatch("read_valid", 8'(o_out_data.read_valid),
                                    8'(want.read_valid));
                if (o_out_data.read_data !== want.read_data)
                    report_mismatch("read_data", o_out_data.read_data, want.read_data);
                if (o_out_data.done_res !== want.done_res)
                    report_mismatch("done_res", 8'(o_out_data.done_res),
                                    8'(want.done_res));
                if (o_out_data.nack_error !== want.nack_error)
                    report_mismatch("nack_error", 8'(o_out_data.nack_error),
                                    8'(want.nack_error));
                if (o_out_data.busy_res !== want.busy_res)
                    report_mismatch("busy_res", 8'(o_out_data.busy_res),
                                    8'(want.busy_res));
            end
            lines_seen++;
        end
    end

    // receiver side, with a long hold-off on request
    always @(posedge i_clk) begin
        if (backpressure_seen != backpressure_req) begin
            backpressure_seen = backpressure_req;
            backpressure_left = HOLD_OFF_CYCLES;
        end
        if (backpressure_left != 0) begin
            backpressure_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready === 1'b1) || (o_out_valid === 1'b1 && i_out_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial begin
        i2cmte_pkg::t_in_word w;
        int ticks;
        int phase_ticks;
        int cnt;
        int nack_at;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_ready = 1'b0;
        engine_reset();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[i]) begin
            case (script[i].kind)
                ROW_IDLE: begin
                    w = i2cmte_pkg::t_in_word'($urandom);
                    w.go = 1'b0;
                    send_word(w, 1'b1, script[i].want);
                end
                ROW_HOLD: begin
                    set_hold(script[i].value);
                end
                default: begin
                    run_txn(script[i].value, script[i].cnt, script[i].nack_at,
                            script[i].wdata, ticks);
                end
            endcase
        end

        for (int p = 0; p < 4; p++) begin
            set_hold(8'($urandom_range(0, 12)));
            gap_pct = GAP_PCT[p];
            stall_pct = STALL_PCT[p];
            if (p == 0)
                backpressure_req++;
            phase_ticks = 0;
            while (phase_ticks < PHASE_TICKS) begin
                if ($urandom_range(99) < 12) begin
                    repeat ($urandom_range(1, 4)) begin
                        w = i2cmte_pkg::t_in_word'($urandom);
                        w.go = 1'b0;
                        send_word(w);
                    end
                end else begin
                    cnt = ($urandom_range(99) < 5) ? $urandom_range(0, 40)
                                                   : $urandom_range(0, 4);
                    nack_at = ($urandom_range(99) < 20) ? $urandom_range(0, cnt) : -1;
                    run_txn(8'($urandom_range(255)), 8'(cnt), nack_at, -1, ticks);
                    phase_ticks += ticks;
                end
            end
        end

        drain();
        repeat (4) @(posedge i_clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ i2c_master_transaction_engine.f @@
src/i2cmte_pkg.sv
src/i2cmte_fsm.sv
src/i2c_master_transaction_engine.sv
dv/tb_i2c_master_transaction_engine.sv
